// File: hdl/rmsn_pkg.sv
// Package for the RMS normalization block: beat payload types, controller
// command and status structs, and shared constants. No dependencies.
package rmsn_pkg;

   localparam int MAX_ROW_LENGTH_DEF = 64;
   localparam int EPS_WIDTH          = 24;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 24'd1;

   localparam int DIV_N_WIDTH = 63;
   localparam int DIV_D_WIDTH = 41;

   typedef struct packed {
      logic signed [15:0] sample;
      logic signed [15:0] gain;
      logic               last_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] normalized;
      logic               last_out;
      logic               row_cut;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic div_sel;
      logic ms_load;
      logic sqrt_start;
      logic issue;
      logic row_clear;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
      logic issue_end;
      logic pipe_empty;
   } status_type;

endpackage

// File: hdl/rmsn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rmsn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/rmsn_div.sv
// Restoring divider, one quotient bit per cycle, 63 steps.
// Depends on rmsn_pkg for operand widths.
module rmsn_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rmsn_pkg::DIV_N_WIDTH-1:0] dividend,
   input  logic [rmsn_pkg::DIV_D_WIDTH-1:0] divisor,
   output logic                            done,
   output logic [rmsn_pkg::DIV_N_WIDTH-1:0] quotient
);
   import rmsn_pkg::*;

   localparam int NW = DIV_N_WIDTH;
   localparam int DW = DIV_D_WIDTH;
   localparam int SW = $clog2(NW);
   localparam logic [SW-1:0] LAST_STEP = SW'(NW - 1);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [SW-1:0] step_ff, step_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW:0]   rem_sh;
   logic [DW+1:0] diff;

   always_comb begin
      rem_sh  = {rem_ff[DW-1:0], quo_ff[NW-1]};
      diff    = {1'b0, rem_sh} - {2'b00, div_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (run_ff) begin
         rem_in  = diff[DW+1] ? rem_sh : diff[DW:0];
         quo_in  = {quo_ff[NW-2:0], ~diff[DW+1]};
         step_in = step_ff + SW'(1);
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/rmsn_dp.sv
// Datapath: row store, square accumulator, divider, root unit and output pipeline.
// Depends on rmsn_pkg, rmsn_ram and rmsn_div.
module rmsn_dp #(
   parameter int MAX_ROW_LENGTH = rmsn_pkg::MAX_ROW_LENGTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rmsn_pkg::cmd_type              cmd,
   output rmsn_pkg::status_type           status,
   input  rmsn_pkg::req_type              req_item,
   input  logic                           csr_write_enable,
   input  logic [rmsn_pkg::EPS_WIDTH-1:0] csr_write_data,
   output logic                           rsp_valid,
   output rmsn_pkg::rsp_type              rsp_item
);
   import rmsn_pkg::*;

   localparam int AW = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
   localparam int CW = $clog2(MAX_ROW_LENGTH + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ROW_LENGTH);
   localparam logic [39:0] ACC_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [DIV_N_WIDTH-1:0] INV_NUM = 63'h4000_0000_0000_0000;
   localparam logic [63:0] ROUND_HALF = 64'h0000_0000_4000_0000;

   // accumulate
   logic [EPS_WIDTH-1:0] eps_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [30:0]          sq_ff, sq_in;
   logic                 sq_vld_ff, sq_vld_in;
   logic [39:0]          acc_ff, acc_in;
   logic signed [31:0]   sq_prod;
   logic [40:0]          acc_sum;
   logic                 store_we;

   // inverse root
   logic                   div_done;
   logic [DIV_N_WIDTH-1:0] div_quo, div_num;
   logic [DIV_D_WIDTH-1:0] div_den;
   logic [40:0]            ms_ff, ms_in, ms_sum;
   logic [63:0]            rad_ff, rad_in;
   logic [34:0]            rem_ff, rem_in, rem_sh, trial;
   logic [31:0]            root_ff, root_in;
   logic [4:0]             sq_step_ff, sq_step_in;
   logic                   sq_run_ff, sq_run_in;
   logic                   sq_done_ff, sq_done_in;

   // emit pipeline
   logic [CW-1:0]      idx_ff, idx_in;
   logic [31:0]        rdata;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic               last1_ff, last2_ff, last3_ff;
   logic               neg2_ff, neg3_ff;
   logic [30:0]        mag2_ff, mag2_in;
   logic signed [31:0] p2;
   logic [62:0]        prod3_ff, prod3_in;
   logic [63:0]        rnd;
   logic [32:0]        r4;
   logic [15:0]        norm4;
   rsp_type            rsp_ff;

   rmsn_ram #(
      .WIDTH(32),
      .DEPTH(MAX_ROW_LENGTH)
   ) u_store (
      .clock(clock),
      .we   (store_we),
      .waddr(count_ff[AW-1:0]),
      .wdata({req_item.sample, req_item.gain}),
      .raddr(idx_ff[AW-1:0]),
      .rdata(rdata)
   );

   assign div_num = cmd.div_sel ? INV_NUM : DIV_N_WIDTH'(acc_ff);
   assign div_den = cmd.div_sel ? ms_ff : DIV_D_WIDTH'(count_ff);

   rmsn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(div_num),
      .divisor (div_den),
      .done    (div_done),
      .quotient(div_quo)
   );

   always_comb begin
      store_we  = cmd.accept && (count_ff < MAX_COUNT);
      sq_prod   = req_item.sample * req_item.sample;
      sq_in     = sq_prod[30:0];
      sq_vld_in = store_we;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      acc_sum   = {1'b0, acc_ff} + 41'(sq_ff);
      acc_in    = acc_ff;
      if (sq_vld_ff) begin
         acc_in = acc_sum[40] ? ACC_MAX : acc_sum[39:0];
      end
      if (store_we) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.accept) begin
         ovf_in = 1'b1;
      end
      if (cmd.row_clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
         acc_in   = '0;
      end
   end

   always_comb begin
      ms_sum = {1'b0, div_quo[39:0]} + 41'(eps_ff);
      ms_in  = ms_ff;
      if (cmd.ms_load) begin
         ms_in = (ms_sum == '0) ? 41'd1 : ms_sum;
      end
   end

   always_comb begin
      rem_sh     = {rem_ff[32:0], rad_ff[63:62]};
      trial      = {1'b0, root_ff, 2'b01};
      rad_in     = rad_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      sq_step_in = sq_step_ff;
      sq_run_in  = sq_run_ff;
      sq_done_in = 1'b0;
      if (cmd.sqrt_start) begin
         rad_in     = {1'b0, div_quo};
         rem_in     = '0;
         root_in    = '0;
         sq_step_in = '0;
         sq_run_in  = 1'b1;
      end else if (sq_run_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[30:0], 1'b0};
         end
         sq_step_in = sq_step_ff + 5'd1;
         if (sq_step_ff == 5'd31) begin
            sq_run_in  = 1'b0;
            sq_done_in = 1'b1;
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.row_clear) begin
         idx_in = '0;
      end else if (cmd.issue) begin
         idx_in = idx_ff + CW'(1);
      end
      p2       = $signed(rdata[31:16]) * $signed(rdata[15:0]);
      mag2_in  = p2[31] ? 31'(-p2) : p2[30:0];
      prod3_in = mag2_ff * root_ff;
      rnd      = {1'b0, prod3_ff} + ROUND_HALF;
      r4       = rnd[63:31];
      if (neg3_ff) begin
         norm4 = (r4 > 33'd32768) ? 16'h8000 : 16'h0000 - r4[15:0];
      end else begin
         norm4 = (r4 > 33'd32767) ? 16'h7FFF : r4[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff     <= EPS_RESET;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         sq_vld_ff  <= 1'b0;
         acc_ff     <= '0;
         sq_run_ff  <= 1'b0;
         sq_done_ff <= 1'b0;
         sq_step_ff <= '0;
         idx_ff     <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            eps_ff <= csr_write_data;
         end
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         sq_vld_ff  <= sq_vld_in;
         acc_ff     <= acc_in;
         sq_run_ff  <= sq_run_in;
         sq_done_ff <= sq_done_in;
         sq_step_ff <= sq_step_in;
         idx_ff     <= idx_in;
         v1_ff      <= cmd.issue;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
      end
      sq_ff    <= sq_in;
      ms_ff    <= ms_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      last1_ff <= status.issue_end;
      last2_ff <= last1_ff;
      last3_ff <= last2_ff;
      neg2_ff  <= p2[31];
      neg3_ff  <= neg2_ff;
      mag2_ff  <= mag2_in;
      prod3_ff <= prod3_in;
      rsp_ff.normalized <= norm4;
      rsp_ff.last_out   <= last3_ff;
      rsp_ff.row_cut    <= ovf_ff;
   end

   assign status.div_done   = div_done;
   assign status.sqrt_done  = sq_done_ff;
   assign status.issue_end  = (idx_ff + CW'(1)) == count_ff;
   assign status.pipe_empty = !(v1_ff || v2_ff || v3_ff);
   assign rsp_valid = v4_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: hdl/rmsn_ctrl.sv
// Controller: sequences load, mean, inverse root and emission of one row.
// Depends on rmsn_pkg for the command and status structs.
module rmsn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_last,
   output logic                 busy,
   output rmsn_pkg::cmd_type    cmd,
   input  rmsn_pkg::status_type status
);
   import rmsn_pkg::*;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DRAIN     = 4'd1;
   localparam logic [3:0] ST_MEAN_GO   = 4'd2;
   localparam logic [3:0] ST_MEAN_WAIT = 4'd3;
   localparam logic [3:0] ST_MS        = 4'd4;
   localparam logic [3:0] ST_INV_GO    = 4'd5;
   localparam logic [3:0] ST_INV_WAIT  = 4'd6;
   localparam logic [3:0] ST_ROOT_GO   = 4'd7;
   localparam logic [3:0] ST_ROOT_WAIT = 4'd8;
   localparam logic [3:0] ST_EMIT      = 4'd9;
   localparam logic [3:0] ST_FLUSH     = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = start;
            if (start && req_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MEAN_GO;
         end
         ST_MEAN_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (status.div_done) begin
               state_in = ST_MS;
            end
         end
         ST_MS: begin
            cmd.ms_load = 1'b1;
            state_in    = ST_INV_GO;
         end
         ST_INV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            state_in      = ST_INV_WAIT;
         end
         ST_INV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_ROOT_GO;
            end
         end
         ST_ROOT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (status.sqrt_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.issue = 1'b1;
            if (status.issue_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.pipe_empty) begin
               cmd.row_clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: hdl/rms_normalization.sv
// RMS normalization top level. Beats are accepted one per cycle while busy is low.
// After the last beat of a row, the results follow two 63-step divisions (mean, then 2^62
// over mean square) and a 32-step root.
// The N results of a row then come out one per cycle on rsp_valid, then busy drops.
// Synchronous reset clears the row state and sets epsilon to 1; the store is not cleared.
// Depends on rmsn_pkg, rmsn_ctrl and rmsn_dp.
module rms_normalization #(
   parameter int MAX_ROW_LENGTH = rmsn_pkg::MAX_ROW_LENGTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  rmsn_pkg::req_type              req_item,
   output logic                           rsp_valid,
   output rmsn_pkg::rsp_type              rsp_item,
   input  logic                           csr_write_enable,
   input  logic [rmsn_pkg::EPS_WIDTH-1:0] csr_write_data
);
   import rmsn_pkg::*;

   cmd_type    cmd;
   status_type status;

   rmsn_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_last(req_item.last_in),
      .busy    (busy),
      .cmd     (cmd),
      .status  (status)
   );

   rmsn_dp #(
      .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_item        (req_item),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_item        (rsp_item)
   );

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Bench for rms_normalization: directed and random rows of beats on the request port,
// each result checked against a scoreboard that recomputes the row in fixed point.
// Depends on rmsn_pkg and the rms_normalization RTL.
module tb;
   import rmsn_pkg::*;

   localparam int ROW_CAP       = MAX_ROW_LENGTH_DEF;
   localparam int RANDOM_BEATS  = 140;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [EPS_WIDTH-1:0] EPS_TOP = '1;
   localparam longint unsigned ACC_TOP = (64'd1 << 40) - 64'd1;

   class rms_scoreboard;
      logic signed [15:0]   row_sample [ROW_CAP];
      logic signed [15:0]   row_gain [ROW_CAP];
      int unsigned          stored;
      longint unsigned      sq_total;
      bit                   cut_seen;
      logic [EPS_WIDTH-1:0] epsilon;
      rsp_type              expected_norms [$];
      int                   errors;

      function new();
         stored     = 0;
         sq_total   = 0;
         cut_seen   = 0;
         epsilon    = EPS_RESET;
         errors     = 0;
      endfunction

      function void set_epsilon(logic [EPS_WIDTH-1:0] value);
         epsilon = value;
      endfunction

      function int pending();
         return expected_norms.size();
      endfunction

      function longint unsigned int_root(longint unsigned a);
         longint unsigned root;
         longint unsigned probe;
         root  = 0;
         probe = 64'd1 << 62;
         while (probe > a) probe >>= 2;
         while (probe != 0) begin
            if (a >= root + probe) begin
               a    = a - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root >>= 1;
            end
            probe >>= 2;
         end
         return root;
      endfunction

      function void note_beat(req_type beat);
         longint unsigned mean_sq;
         longint unsigned inv_rms;
         longint unsigned mag;
         longint unsigned rounded;
         longint          prod;
         longint          value;
         rsp_type         res;
         if (stored < ROW_CAP) begin
            row_sample[stored] = beat.sample;
            row_gain[stored]   = beat.gain;
            stored++;
            sq_total += longint'(beat.sample) * longint'(beat.sample);
            if (sq_total > ACC_TOP) sq_total = ACC_TOP;
         end else begin
            cut_seen = 1'b1;
         end
         if (!beat.last_in) return;
         mean_sq = sq_total / stored + epsilon;
         if (mean_sq == 0) mean_sq = 1;
         inv_rms = int_root((64'd1 << 62) / mean_sq);
         for (int i = 0; i < stored; i++) begin
            prod    = longint'(row_sample[i]) * longint'(row_gain[i]);
            mag     = (prod < 0) ? -prod : prod;
            rounded = (mag * inv_rms + (64'd1 << 30)) >> 31;
            if (prod < 0) begin
               value = (rounded > 32768) ? -32768 : -longint'(rounded);
            end else begin
               value = (rounded > 32767) ? 32767 : longint'(rounded);
            end
            res.normalized = value[15:0];
            res.last_out   = (i + 1 == stored);
            res.row_cut    = cut_seen;
            expected_norms.push_back(res);
         end
         stored     = 0;
         sq_total   = 0;
         cut_seen   = 1'b0;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_norms.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %0d last %0b cut %0b",
                     $time, got.normalized, got.last_out, got.row_cut);
            return;
         end
         want = expected_norms.pop_front();
         if (got !== want) begin
            errors++;
            $display({"%0t: result mismatch, expected %0d last %0b cut %0b,",
                      " actual %0d last %0b cut %0b"},
                     $time, want.normalized, want.last_out, want.row_cut,
                     got.normalized, got.last_out, got.row_cut);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_item;
   logic                 rsp_valid;
   rsp_type              rsp_item;
   logic                 csr_write_enable;
   logic [EPS_WIDTH-1:0] csr_write_data;

   rms_scoreboard sb = new();
   int burst_left   = 0;
   int quiet_cycles = 0;
   int beats_sent   = 0;

   rms_normalization uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid) sb.check_result(rsp_item);
         if (start && !busy) sb.note_beat(req_item);
         if (csr_write_enable) sb.set_epsilon(csr_write_data);
         quiet_cycles <= (rsp_valid || (start && !busy)) ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   function automatic logic signed [15:0] rand_value(int span);
      int v;
      v = int'($urandom_range(0, 2 * span - 1)) - span;
      return 16'(v);
   endfunction

   task automatic drive_beat(input logic signed [15:0] smp, input logic signed [15:0] gn,
                             input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      start    <= 1'b1;
      req_item <= '{sample: smp, gain: gn, last_in: last};
      do begin
         @(posedge clock);
      end while (busy);
      beats_sent++;
   endtask

   task automatic drain_block();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_epsilon(input logic [EPS_WIDTH-1:0] value);
      drain_block();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_row(input int len, input int span);
      for (int i = 0; i < len; i++) begin
         drive_beat(rand_value(span), 16'($urandom), i == len - 1);
      end
   endtask

   initial begin
      int directed_beats;
      int target;
      int len;
      int span;
      logic [EPS_WIDTH-1:0] eps;

      reset            = 1'b1;
      start            = 1'b0;
      req_item         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // single-beat and two-beat rows at the corners, with the reset epsilon
      drive_beat(16'sd32767, 16'sd32767, 1'b1);
      drive_beat(-16'sd32768, -16'sd32768, 1'b1);
      drive_beat(-16'sd32768, 16'sd32767, 1'b0);
      drive_beat(16'sd32767, -16'sd32768, 1'b1);
      // one large sample among zeros: saturate high, then low; then a row of small samples
      drive_beat(16'sd32767, 16'sd32767, 1'b0);
      drive_beat(16'sd0, -16'sd32768, 1'b0);
      drive_beat(16'sd0, 16'sd0, 1'b0);
      drive_beat(16'sd0, 16'sd0, 1'b1);
      drive_beat(-16'sd32768, 16'sd32767, 1'b0);
      drive_beat(16'sd0, 16'sd1, 1'b0);
      drive_beat(16'sd0, 16'sd0, 1'b0);
      drive_beat(16'sd0, 16'sd0, 1'b1);
      drive_beat(16'sd1, 16'sd1, 1'b0);
      drive_beat(-16'sd1, 16'sd4096, 1'b0);
      drive_beat(16'sd0, 16'sd0, 1'b1);

      // zero mean square
      write_epsilon('0);
      drive_beat(16'sd0, 16'sd4096, 1'b0);
      drive_beat(16'sd0, -16'sd4096, 1'b1);

      write_epsilon(EPS_TOP);
      drive_beat(16'sd1, 16'sd32767, 1'b1);
      drive_beat(16'sd32767, 16'sd32767, 1'b1);

      // overlong row: last beat falls beyond the store and is dropped
      write_epsilon(EPS_RESET);
      send_random_row(ROW_CAP + 1, 32768);

      directed_beats = beats_sent;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       eps = $urandom_range(1, EPS_TOP);
            1:       eps = $urandom_range(1, 255);
            2:       eps = EPS_TOP;
            default: eps = EPS_RESET;
         endcase
         write_epsilon(eps);
         target = directed_beats + (phase + 1) * RANDOM_BEATS / 4;
         while (beats_sent < target) begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(ROW_CAP - 4, ROW_CAP + 6);
            else len = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
               0:       span = 32768;
               1:       span = 4096;
               2:       span = 64;
               default: span = 2;
            endcase
            send_random_row(len, span);
         end
      end

      drain_block();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
